@@ rtl/core/urc_pkg.sv @@
`default_nettype none

package urc_pkg;

  localparam int unsigned TRIG_HIGH_TICKS = 10;
  localparam int unsigned TRIG_LOW_TICKS  = 2;
  localparam int unsigned RANGE_DIVISOR   = 6;

  localparam int unsigned MM_W    = 13;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned DIST_MAX  = (1 << DIST_W) - 1;
  localparam int unsigned DIV_SHIFT = PULSE_W + 8;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + RANGE_DIVISOR - 1) / RANGE_DIVISOR;

  localparam logic [MM_W-1:0]    NEAR_LIMIT_RST = MM_W'(150);
  localparam logic [MM_W-1:0]    BAND_LOW_RST   = MM_W'(200);
  localparam logic [MM_W-1:0]    BAND_HIGH_RST  = MM_W'(600);
  localparam logic [LIMIT_W-1:0] ECHO_WAIT_RST  = LIMIT_W'(40000);
  localparam logic [LIMIT_W-1:0] ECHO_HIGH_RST  = LIMIT_W'(30000);
  localparam logic [CNT_W-1:0]   DEBOUNCE_RST   = CNT_W'(200000);
  localparam logic [CNT_W-1:0]   PAUSE_RST      = CNT_W'(100000);

  localparam logic [1:0] LED_OFF    = 2'b00;
  localparam logic [1:0] LED_GREEN  = 2'b01;
  localparam logic [1:0] LED_RED    = 2'b10;
  localparam logic [1:0] LED_YELLOW = 2'b11;

  typedef enum logic [2:0] {
    PH_OFF,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE,
    PH_PAUSE
  } urc_phase_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_DONE,
    ST_RISE_TIMEOUT,
    ST_HIGH_TIMEOUT
  } urc_status_t;

  typedef enum logic [2:0] {
    REG_NEAR_LIMIT,
    REG_BAND_LOW,
    REG_BAND_HIGH,
    REG_ECHO_WAIT,
    REG_ECHO_HIGH,
    REG_DEBOUNCE,
    REG_PAUSE
  } urc_reg_t;

  typedef struct packed {
    logic echo_level;
    logic button_level;
  } urc_in_t;

  typedef struct packed {
    logic               trig_level;
    logic               led_red;
    logic               led_green;
    logic               sensor_on;
    logic [1:0]         reading_status;
    logic [PULSE_W-1:0] pulse_ticks;
    logic [DIST_W-1:0]  distance_mm;
  } urc_out_t;

  typedef struct packed {
    logic [MM_W-1:0]    near_limit_mm;
    logic [MM_W-1:0]    band_low_mm;
    logic [MM_W-1:0]    band_high_mm;
    logic [LIMIT_W-1:0] echo_wait_limit;
    logic [LIMIT_W-1:0] echo_high_limit;
    logic [CNT_W-1:0]   debounce_ticks;
    logic [CNT_W-1:0]   pause_ticks;
  } urc_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/urc_cfg.sv @@
`default_nettype none

module urc_cfg
  import urc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output urc_cfg_t               cfg
);

  urc_cfg_t cfg_r;
  urc_reg_t sel;
  logic     wr_en;

  assign sel    = urc_reg_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_limit_mm   <= NEAR_LIMIT_RST;
      cfg_r.band_low_mm     <= BAND_LOW_RST;
      cfg_r.band_high_mm    <= BAND_HIGH_RST;
      cfg_r.echo_wait_limit <= ECHO_WAIT_RST;
      cfg_r.echo_high_limit <= ECHO_HIGH_RST;
      cfg_r.debounce_ticks  <= DEBOUNCE_RST;
      cfg_r.pause_ticks     <= PAUSE_RST;
    end else if (wr_en) begin
      unique case (sel)
        REG_NEAR_LIMIT: cfg_r.near_limit_mm   <= pwdata[MM_W-1:0];
        REG_BAND_LOW:   cfg_r.band_low_mm     <= pwdata[MM_W-1:0];
        REG_BAND_HIGH:  cfg_r.band_high_mm    <= pwdata[MM_W-1:0];
        REG_ECHO_WAIT:  cfg_r.echo_wait_limit <= pwdata[LIMIT_W-1:0];
        REG_ECHO_HIGH:  cfg_r.echo_high_limit <= pwdata[LIMIT_W-1:0];
        REG_DEBOUNCE:   cfg_r.debounce_ticks  <= pwdata[CNT_W-1:0];
        REG_PAUSE:      cfg_r.pause_ticks     <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_NEAR_LIMIT: prdata = DATA_W'(cfg_r.near_limit_mm);
      REG_BAND_LOW:   prdata = DATA_W'(cfg_r.band_low_mm);
      REG_BAND_HIGH:  prdata = DATA_W'(cfg_r.band_high_mm);
      REG_ECHO_WAIT:  prdata = DATA_W'(cfg_r.echo_wait_limit);
      REG_ECHO_HIGH:  prdata = DATA_W'(cfg_r.echo_high_limit);
      REG_DEBOUNCE:   prdata = DATA_W'(cfg_r.debounce_ticks);
      REG_PAUSE:      prdata = DATA_W'(cfg_r.pause_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/urc_ranging.sv @@
`default_nettype none

module urc_ranging
  import urc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire urc_in_t  item,
  input  wire urc_cfg_t cfg,
  output urc_out_t      result
);

  urc_phase_t         phase_r, phase_nxt;
  logic [CNT_W-1:0]   phase_count_r, phase_count_nxt;
  logic [PULSE_W-1:0] pulse_count_r, pulse_count_nxt;
  logic               enabled_r, enabled_nxt;
  logic               acc_btn_r, acc_btn_nxt;
  logic [CNT_W-1:0]   deb_count_r, deb_count_nxt;
  logic               deb_busy_r, deb_busy_nxt;
  logic [1:0]         led_r, led_nxt;

  logic [CNT_W-1:0]             deb_inc;
  logic [CNT_W-1:0]             pc_inc;
  logic [PULSE_W:0]             pls_inc;
  logic [PULSE_W+RECIP_W-1:0]   prod;
  logic [PULSE_W:0]             quot;
  logic [DIST_W-1:0]            range_mm;
  urc_status_t                  status;
  logic                         trig;

  // The divide by the range divisor is a multiply by its rounded-up reciprocal.
  assign prod = PULSE_W'(pulse_count_r) * RECIP_W'(DIV_RECIP);
  assign quot = prod[PULSE_W+RECIP_W-1:DIV_SHIFT];
  assign range_mm = (quot > (PULSE_W+1)'(DIST_MAX)) ? DIST_W'(DIST_MAX) : quot[DIST_W-1:0];

  assign deb_inc = (deb_count_r != '1) ? deb_count_r + 1'b1 : deb_count_r;

  always_comb begin
    phase_nxt       = phase_r;
    phase_count_nxt = phase_count_r;
    pulse_count_nxt = pulse_count_r;
    enabled_nxt     = enabled_r;
    acc_btn_nxt     = acc_btn_r;
    deb_count_nxt   = deb_count_r;
    deb_busy_nxt    = deb_busy_r;
    led_nxt         = led_r;
    status          = ST_NONE;
    trig            = 1'b0;
    pls_inc         = '0;

    if (!deb_busy_r) begin
      if (item.button_level != acc_btn_r) begin
        deb_busy_nxt  = 1'b1;
        deb_count_nxt = '0;
      end
    end else if (deb_inc >= cfg.debounce_ticks) begin
      deb_busy_nxt  = 1'b0;
      deb_count_nxt = '0;
      if (item.button_level != acc_btn_r) begin
        acc_btn_nxt = item.button_level;
        if (item.button_level) begin
          enabled_nxt     = !enabled_r;
          phase_count_nxt = '0;
          if (!enabled_r) begin
            led_nxt   = LED_GREEN;
            phase_nxt = PH_TRIG_LOW;
          end else begin
            led_nxt   = LED_OFF;
            phase_nxt = PH_OFF;
          end
        end
      end
    end else begin
      deb_count_nxt = deb_inc;
    end

    pc_inc = phase_count_nxt + 1'b1;

    unique case (phase_nxt)
      PH_TRIG_LOW: begin
        phase_count_nxt = pc_inc;
        if (pc_inc >= CNT_W'(TRIG_LOW_TICKS)) begin
          phase_nxt       = PH_TRIG_HIGH;
          phase_count_nxt = '0;
        end
      end
      PH_TRIG_HIGH: begin
        trig            = 1'b1;
        phase_count_nxt = pc_inc;
        if (pc_inc >= CNT_W'(TRIG_HIGH_TICKS)) begin
          phase_nxt       = PH_WAIT_RISE;
          phase_count_nxt = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (item.echo_level) begin
          phase_count_nxt = '0;
          pls_inc         = (PULSE_W+1)'(1);
          if (pls_inc > {1'b0, cfg.echo_high_limit}) begin
            phase_nxt       = PH_PAUSE;
            pulse_count_nxt = '0;
            status          = ST_HIGH_TIMEOUT;
          end else begin
            phase_nxt       = PH_MEASURE;
            pulse_count_nxt = pls_inc[PULSE_W-1:0];
          end
        end else begin
          phase_count_nxt = pc_inc;
          if (pc_inc > CNT_W'(cfg.echo_wait_limit)) begin
            phase_nxt       = PH_PAUSE;
            phase_count_nxt = '0;
            status          = ST_RISE_TIMEOUT;
          end
        end
      end
      PH_MEASURE: begin
        if (item.echo_level) begin
          pls_inc = {1'b0, pulse_count_r} + 1'b1;
          if (pls_inc > {1'b0, cfg.echo_high_limit}) begin
            phase_nxt       = PH_PAUSE;
            phase_count_nxt = '0;
            status          = ST_HIGH_TIMEOUT;
          end else begin
            pulse_count_nxt = pls_inc[PULSE_W-1:0];
          end
        end else begin
          phase_nxt       = PH_PAUSE;
          phase_count_nxt = '0;
          status          = ST_DONE;
        end
      end
      PH_PAUSE: begin
        phase_count_nxt = pc_inc;
        if (pc_inc >= cfg.pause_ticks) begin
          phase_nxt       = PH_TRIG_LOW;
          phase_count_nxt = '0;
        end
      end
      default: begin
        phase_nxt       = PH_OFF;
        phase_count_nxt = '0;
      end
    endcase

    if (status == ST_DONE && range_mm != '0) begin
      if (range_mm < DIST_W'(cfg.near_limit_mm)) begin
        led_nxt = LED_RED;
      end else if (range_mm > DIST_W'(cfg.band_low_mm) &&
                   range_mm < DIST_W'(cfg.band_high_mm)) begin
        led_nxt = LED_YELLOW;
      end else begin
        led_nxt = LED_GREEN;
      end
    end
  end

  always_comb begin
    result.trig_level     = trig;
    result.led_red        = led_nxt[1];
    result.led_green      = led_nxt[0];
    result.sensor_on      = enabled_nxt;
    result.reading_status = status;
    result.pulse_ticks    = (status == ST_DONE) ? pulse_count_r : '0;
    result.distance_mm    = (status == ST_DONE) ? range_mm : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OFF;
      phase_count_r <= '0;
      pulse_count_r <= '0;
      enabled_r     <= 1'b0;
      acc_btn_r     <= 1'b0;
      deb_count_r   <= '0;
      deb_busy_r    <= 1'b0;
      led_r         <= LED_OFF;
    end else if (step) begin
      phase_r       <= phase_nxt;
      phase_count_r <= phase_count_nxt;
      pulse_count_r <= pulse_count_nxt;
      enabled_r     <= enabled_nxt;
      acc_btn_r     <= acc_btn_nxt;
      deb_count_r   <= deb_count_nxt;
      deb_busy_r    <= deb_busy_nxt;
      led_r         <= led_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ultrasonic_range_controller_unit.sv @@
// Ultrasonic ranging controller, one input item per microsecond tick and exactly
// one result item per input item. An item is taken into an input register,
// the debounce, trigger, echo timing and distance logic runs on it combinationally,
// and the result lands in an output register. The block sustains one item per
// clock while out_stall is low. The input register doubles as a skid stage, so
// one item is still taken while a result waits on out_stall. Thresholds, timeouts,
// the debounce time and the pause length are APB registers at byte addresses 0
// to 24, to be written while no items are in flight.
`default_nettype none

module ultrasonic_range_controller_unit
  import urc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire urc_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output urc_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  urc_cfg_t cfg;
  urc_in_t  item_r;
  logic     item_vld_r;
  urc_out_t res;
  urc_out_t res_r;
  logic     res_vld_r;
  logic     adv;

  assign adv       = item_vld_r && (!res_vld_r || !out_stall);
  assign in_stall  = item_vld_r && !adv;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  urc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  urc_ranging u_ranging (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .item   (item_r),
    .cfg    (cfg),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        item_vld_r <= 1'b1;
      end else if (adv) begin
        item_vld_r <= 1'b0;
      end
      if (adv) begin
        res_vld_r <= 1'b1;
      end else if (!out_stall) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    if (adv) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/urc_checker.sv @@
`default_nettype none

module urc_checker
  import urc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire urc_out_t          out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  a_status_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reading_status != ST_NONE |-> out_data.sensor_on)
    else $error("reading reported while sensor is off");

  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sensor_on |->
      !out_data.led_red && !out_data.led_green && !out_data.trig_level)
    else $error("LED or trigger active while sensor is off");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reading_status != ST_DONE |->
      out_data.pulse_ticks == '0 && out_data.distance_mm == '0)
    else $error("pulse or distance nonzero without a finished reading");

endmodule

bind ultrasonic_range_controller_unit urc_checker u_urc_checker (.*);

`default_nettype wire

@@ tb/tb_ultrasonic_range_controller_unit.sv @@
`default_nettype none

module tb_ultrasonic_range_controller_unit;
  import urc_pkg::*;

  class ranging_board;
    urc_cfg_t    cfg;
    urc_phase_t  phase;
    logic [CNT_W-1:0]   phase_count;
    logic [PULSE_W-1:0] pulse_count;
    logic        ranging_on;
    logic        btn_taken;
    logic [CNT_W-1:0]   settle_count;
    logic        settle_busy;
    logic [1:0]  leds;
    urc_out_t    expected_readings[$];
    int unsigned mismatch_count;

    function new();
      cfg.near_limit_mm   = NEAR_LIMIT_RST;
      cfg.band_low_mm     = BAND_LOW_RST;
      cfg.band_high_mm    = BAND_HIGH_RST;
      cfg.echo_wait_limit = ECHO_WAIT_RST;
      cfg.echo_high_limit = ECHO_HIGH_RST;
      cfg.debounce_ticks  = DEBOUNCE_RST;
      cfg.pause_ticks     = PAUSE_RST;
      phase          = PH_OFF;
      phase_count    = '0;
      pulse_count    = '0;
      ranging_on     = 1'b0;
      btn_taken      = 1'b0;
      settle_count   = '0;
      settle_busy    = 1'b0;
      leds           = LED_OFF;
      mismatch_count = 0;
    endfunction

    function void set_reg(urc_reg_t idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_NEAR_LIMIT: cfg.near_limit_mm   = val[MM_W-1:0];
        REG_BAND_LOW:   cfg.band_low_mm     = val[MM_W-1:0];
        REG_BAND_HIGH:  cfg.band_high_mm    = val[MM_W-1:0];
        REG_ECHO_WAIT:  cfg.echo_wait_limit = val[LIMIT_W-1:0];
        REG_ECHO_HIGH:  cfg.echo_high_limit = val[LIMIT_W-1:0];
        REG_DEBOUNCE:   cfg.debounce_ticks  = val[CNT_W-1:0];
        REG_PAUSE:      cfg.pause_ticks     = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void switch_phase(urc_phase_t p);
      phase       = p;
      phase_count = '0;
    endfunction

    function urc_status_t echo_step(logic echo);
      if (echo) begin
        if (32'(pulse_count) + 1 > 32'(cfg.echo_high_limit)) begin
          switch_phase(PH_PAUSE);
          return ST_HIGH_TIMEOUT;
        end
        pulse_count = pulse_count + 1'b1;
        return ST_NONE;
      end
      switch_phase(PH_PAUSE);
      return ST_DONE;
    endfunction

    function urc_out_t predict_tick(urc_in_t t);
      urc_out_t    r;
      urc_status_t st;
      logic [PULSE_W-1:0] pulse;
      int unsigned quot;
      r     = '0;
      st    = ST_NONE;
      pulse = '0;
      quot  = 0;

      if (!settle_busy) begin
        if (t.button_level != btn_taken) begin
          settle_busy  = 1'b1;
          settle_count = '0;
        end
      end else begin
        if (settle_count != '1) settle_count = settle_count + 1'b1;
        if (settle_count >= cfg.debounce_ticks) begin
          settle_busy  = 1'b0;
          settle_count = '0;
          if (t.button_level != btn_taken) begin
            btn_taken = t.button_level;
            if (t.button_level) begin
              ranging_on = !ranging_on;
              if (ranging_on) begin
                leds = LED_GREEN;
                switch_phase(PH_TRIG_LOW);
              end else begin
                leds = LED_OFF;
                switch_phase(PH_OFF);
              end
            end
          end
        end
      end

      case (phase)
        PH_TRIG_LOW: begin
          phase_count = phase_count + 1'b1;
          if (phase_count >= TRIG_LOW_TICKS) switch_phase(PH_TRIG_HIGH);
        end
        PH_TRIG_HIGH: begin
          r.trig_level = 1'b1;
          phase_count  = phase_count + 1'b1;
          if (phase_count >= TRIG_HIGH_TICKS) switch_phase(PH_WAIT_RISE);
        end
        PH_WAIT_RISE: begin
          if (t.echo_level) begin
            switch_phase(PH_MEASURE);
            pulse_count = '0;
            st = echo_step(1'b1);
          end else begin
            phase_count = phase_count + 1'b1;
            if (phase_count > cfg.echo_wait_limit) begin
              switch_phase(PH_PAUSE);
              st = ST_RISE_TIMEOUT;
            end
          end
        end
        PH_MEASURE: st = echo_step(t.echo_level);
        PH_PAUSE: begin
          phase_count = phase_count + 1'b1;
          if (phase_count >= cfg.pause_ticks) switch_phase(PH_TRIG_LOW);
        end
        default: switch_phase(PH_OFF);
      endcase

      if (st == ST_DONE) begin
        pulse = pulse_count;
        quot  = pulse / RANGE_DIVISOR;
        if (quot > DIST_MAX) quot = DIST_MAX;
        if (quot != 0) begin
          if (quot < cfg.near_limit_mm) leds = LED_RED;
          else if (quot > cfg.band_low_mm && quot < cfg.band_high_mm) leds = LED_YELLOW;
          else leds = LED_GREEN;
        end
      end

      r.led_red        = leds[1];
      r.led_green      = leds[0];
      r.sensor_on      = ranging_on;
      r.reading_status = st;
      r.pulse_ticks    = pulse;
      r.distance_mm    = DIST_W'(quot);
      return r;
    endfunction

    function void note_tick(urc_in_t t);
      expected_readings.push_back(predict_tick(t));
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        mismatch_count++;
      end
    endfunction

    function void check_tick(urc_out_t got);
      urc_out_t exp;
      if (expected_readings.size() == 0) begin
        $error("result item arrived with no item outstanding");
        mismatch_count++;
        return;
      end
      exp = expected_readings.pop_front();
      check_field("trig_level", exp.trig_level, got.trig_level);
      check_field("led_red", exp.led_red, got.led_red);
      check_field("led_green", exp.led_green, got.led_green);
      check_field("sensor_on", exp.sensor_on, got.sensor_on);
      check_field("reading_status", exp.reading_status, got.reading_status);
      check_field("pulse_ticks", exp.pulse_ticks, got.pulse_ticks);
      check_field("distance_mm", exp.distance_mm, got.distance_mm);
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  urc_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  urc_out_t          out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ranging_board sb;
  int unsigned  idle_pct;
  int unsigned  stall_pct;
  int unsigned  ticks_sent;
  int unsigned  settle_len;
  int unsigned  echo_low_max;
  int unsigned  echo_high_max;

  ultrasonic_range_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_pct != 0 && $urandom_range(99) < stall_pct) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_tick(out_data);
  end

  task automatic send_tick(input logic echo, input logic btn);
    urc_in_t d;
    bit      taken;
    d.echo_level   = echo;
    d.button_level = btn;
    taken          = 1'b0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) sb.note_tick(d);
      @(posedge clk);
    end
    ticks_sent++;
  endtask

  task automatic hold(input logic echo, input logic btn, input int unsigned n);
    repeat (n) send_tick(echo, btn);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input urc_reg_t idx, input logic [DATA_W-1:0] val);
    bit done;
    done = 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    while (!done) begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned near, input int unsigned band_lo,
                           input int unsigned band_hi, input int unsigned wait_lim,
                           input int unsigned high_lim, input int unsigned settle,
                           input int unsigned pause_len);
    cfg_write(REG_NEAR_LIMIT, near);
    cfg_write(REG_BAND_LOW, band_lo);
    cfg_write(REG_BAND_HIGH, band_hi);
    cfg_write(REG_ECHO_WAIT, wait_lim);
    cfg_write(REG_ECHO_HIGH, high_lim);
    cfg_write(REG_DEBOUNCE, settle);
    cfg_write(REG_PAUSE, pause_len);
    settle_len    = settle;
    echo_low_max  = (wait_lim + 3 > 24) ? 24 : wait_lim + 3;
    echo_high_max = (high_lim + 3 > 48) ? 48 : high_lim + 3;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 75; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 75; end
      default: begin idle_pct = 28; stall_pct = 28; end
    endcase
  endtask

  task automatic press_button();
    hold(1'b0, 1'b1, settle_len + 2);
    hold(1'b0, 1'b0, settle_len + 2);
  endtask

  task automatic random_ticks(input int unsigned count, input bit presses);
    int unsigned goal;
    int unsigned pick;
    goal = ticks_sent + count;
    while (ticks_sent < goal) begin
      pick = $urandom_range(99);
      if (presses && (!sb.ranging_on || pick < 4)) begin
        press_button();
      end else if (pick < 12) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        hold(1'b0, 1'b0, $urandom_range(0, echo_low_max));
        hold(1'b1, 1'b0, $urandom_range(1, echo_high_max));
      end
    end
  endtask

  initial begin
    sb         = new();
    idle_pct   = 0;
    stall_pct  = 0;
    ticks_sent = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Switch on, one full trigger, a short echo read as red, then switch off
    // while the next trigger is low.
    configure(2, 1, 4, 2, 8, 1, 0);
    hold(1'b0, 1'b1, 2);
    hold(1'b0, 1'b0, 2);
    hold(1'b0, 1'b0, 9);
    hold(1'b1, 1'b0, 7);
    hold(1'b0, 1'b0, 2);
    hold(1'b1, 1'b1, 2);
    hold(1'b0, 1'b0, 2);
    drain();

    for (int p = 0; p < 6; p++) begin
      configure($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(2, 8),
                $urandom_range(1, 8), $urandom_range(1, 40), $urandom_range(1, 4),
                $urandom_range(0, 6));
      set_idling(p % 4);
      random_ticks(75, 1'b1);
      drain();
    end

    configure(5000, 5000, 5000, 65535, 65535, 262143, 262143);
    set_idling(3);
    random_ticks(40, 1'b0);
    drain();

    configure(0, 0, 0, 1, 1, 1, 0);
    set_idling(0);
    random_ticks(40, 1'b1);
    drain();

    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/urc_pkg.sv
rtl/core/urc_cfg.sv
rtl/core/urc_ranging.sv
rtl/core/ultrasonic_range_controller_unit.sv
rtl/core/urc_checker.sv
tb/tb_ultrasonic_range_controller_unit.sv
